@@ hdl/sorted_insertion_list_assert.svh @@
// ----------------------------------------------------------------------------
// sorted insertion list assertion macros
// shared property shorthands for the checker files
// ----------------------------------------------------------------------------
`ifndef SORTED_INSERTION_LIST_ASSERT_SVH
`define SORTED_INSERTION_LIST_ASSERT_SVH

// same-cycle implication, disabled during reset
`define SIL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define SIL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/sil_pkg.sv @@
// ----------------------------------------------------------------------------
// sil_pkg
// constants, beat types and helpers of the sorted insertion list
// ----------------------------------------------------------------------------
package sil_pkg;

  localparam int CAPACITY = 32;
  localparam int TAG_BITS = 16;

  localparam int ADDR_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W   = $clog2(CAPACITY + 1);
  localparam int KEY_W   = 16;
  localparam int ENTRY_W = KEY_W + TAG_BITS;

  localparam logic [6:0] DAY_MAX    = 7'd31;
  localparam logic [4:0] HOUR_MAX   = 5'd23;
  localparam logic [5:0] MINUTE_MAX = 6'd59;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_LIST   = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  localparam logic [2:0] STAT_INSERTED = 3'd0;
  localparam logic [2:0] STAT_BAD_FMT  = 3'd1;
  localparam logic [2:0] STAT_FULL     = 3'd2;
  localparam logic [2:0] STAT_LISTED   = 3'd3;
  localparam logic [2:0] STAT_EMPTY    = 3'd4;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [6:0]  entry_day;
    logic [4:0]  entry_hour;
    logic [5:0]  entry_minute;
    logic [15:0] entry_tag;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [4:0]  out_day;
    logic [4:0]  out_hour;
    logic [5:0]  out_minute;
    logic [15:0] out_tag;
    logic        last;
    logic [5:0]  entry_count;
  } out_beat_t;

  function automatic logic [TAG_BITS-1:0] tag_store_fmt(logic [15:0] tag);
    logic [63:0] w;
    w = 64'(tag);
    return w[TAG_BITS-1:0];
  endfunction

  function automatic logic [15:0] tag_out_fmt(logic [TAG_BITS-1:0] tag);
    logic [63:0] w;
    w = 64'(tag);
    return w[15:0];
  endfunction

  function automatic logic [5:0] count_out_fmt(logic [CNT_W-1:0] cnt);
    logic [7:0] w;
    w = 8'(cnt);
    return w[5:0];
  endfunction

endpackage

@@ hdl/sil_ram.sv @@
// ----------------------------------------------------------------------------
// sil_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module sil_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                         wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ hdl/sorted_insertion_list.sv @@
// ----------------------------------------------------------------------------
// sorted_insertion_list
// list of dated entries kept sorted by day, hour and minute in one ram
// ----------------------------------------------------------------------------
// usage:
//   a command beat on in_data is taken when start is high and busy is low.
//   insert validates the date fields, then walks the list from the tail,
//   moving each larger entry up one slot, one entry per cycle, and writes
//   the new entry into the gap; equal keys keep arrival order.
//   list reads the ram from the head and emits one listed entry per cycle,
//   last marks the final one. clear drops the count to zero at once.
// results leave on out_data with a one-cycle out_valid strobe; the
//   receiver cannot stall, so every beat must be taken when shown.
// timing: each result is registered before it shows on out_data. rejected
//   inserts, clear, list of an empty list and an insert into an empty list
//   finish in the idle state; an insert moves past one entry per step, each
//   step waiting on the registered ram read, and a list emits one entry per
//   step. the single ram read port sets the pace; busy holds off commands.
// reset empties the list; no clearing pass is needed.
// ----------------------------------------------------------------------------
module sorted_insertion_list
  import sil_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_beat_t  in_data,
  output logic      out_valid,
  output out_beat_t out_data
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_PLACE = 2'd2;
  localparam logic [1:0] ST_LIST  = 2'd3;

  logic [1:0]         state_r, state_nxt;
  logic [ADDR_W-1:0]  idx_r, idx_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [ENTRY_W-1:0] new_r, new_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_beat_t          out_data_r, out_data_nxt;

  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  logic [ENTRY_W-1:0] wr_data;
  logic [ADDR_W-1:0]  rd_addr;
  logic [ENTRY_W-1:0] rd_data;

  logic               fmt_bad;
  logic [ENTRY_W-1:0] in_entry;
  logic [ADDR_W-1:0]  idx_inc;
  logic               idx_is_tail;

  sil_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign fmt_bad = (in_data.entry_day == 7'd0) || (in_data.entry_day > DAY_MAX) ||
                   (in_data.entry_hour > HOUR_MAX) || (in_data.entry_minute > MINUTE_MAX);
  assign in_entry = {in_data.entry_day[4:0], in_data.entry_hour, in_data.entry_minute,
                     tag_store_fmt(in_data.entry_tag)};
  assign idx_inc     = ADDR_W'(idx_r + ADDR_W'(1));
  assign idx_is_tail = ((CNT_W'(idx_r) + CNT_W'(1)) == count_r);

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    count_nxt     = count_r;
    new_nxt       = new_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = '0;
    wr_en         = 1'b0;
    wr_addr       = idx_inc;
    wr_data       = new_r;
    rd_addr       = idx_r;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          unique case (in_data.cmd)
            CMD_INSERT: begin
              out_valid_nxt     = 1'b1;
              out_data_nxt.last = 1'b1;
              if (fmt_bad) begin
                out_data_nxt.status = STAT_BAD_FMT;
              end else if (count_r >= CNT_W'(CAPACITY)) begin
                out_data_nxt.status = STAT_FULL;
              end else if (count_r == '0) begin
                wr_en               = 1'b1;
                wr_addr             = '0;
                wr_data             = in_entry;
                count_nxt           = CNT_W'(1);
                out_data_nxt.status = STAT_INSERTED;
              end else begin
                out_valid_nxt = 1'b0;
                new_nxt       = in_entry;
                rd_addr       = ADDR_W'(count_r - CNT_W'(1));
                idx_nxt       = ADDR_W'(count_r - CNT_W'(1));
                state_nxt     = ST_SCAN;
              end
            end
            CMD_LIST: begin
              if (count_r == '0) begin
                out_valid_nxt       = 1'b1;
                out_data_nxt.status = STAT_EMPTY;
                out_data_nxt.last   = 1'b1;
              end else begin
                rd_addr   = '0;
                idx_nxt   = '0;
                state_nxt = ST_LIST;
              end
            end
            CMD_CLEAR: begin
              count_nxt           = '0;
              out_valid_nxt       = 1'b1;
              out_data_nxt.status = STAT_EMPTY;
              out_data_nxt.last   = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        wr_en = 1'b1;
        if (rd_data[ENTRY_W-1 -: KEY_W] > new_r[ENTRY_W-1 -: KEY_W]) begin
          // larger entry moves up one slot
          wr_data = rd_data;
          if (idx_r == '0) begin
            state_nxt = ST_PLACE;
          end else begin
            rd_addr = ADDR_W'(idx_r - ADDR_W'(1));
            idx_nxt = ADDR_W'(idx_r - ADDR_W'(1));
          end
        end else begin
          count_nxt           = CNT_W'(count_r + CNT_W'(1));
          out_valid_nxt       = 1'b1;
          out_data_nxt.status = STAT_INSERTED;
          out_data_nxt.last   = 1'b1;
          state_nxt           = ST_IDLE;
        end
      end
      ST_PLACE: begin
        wr_en               = 1'b1;
        wr_addr             = '0;
        count_nxt           = CNT_W'(count_r + CNT_W'(1));
        out_valid_nxt       = 1'b1;
        out_data_nxt.status = STAT_INSERTED;
        out_data_nxt.last   = 1'b1;
        state_nxt           = ST_IDLE;
      end
      ST_LIST: begin
        out_valid_nxt           = 1'b1;
        out_data_nxt.status     = STAT_LISTED;
        out_data_nxt.out_day    = rd_data[ENTRY_W-1 -: 5];
        out_data_nxt.out_hour   = rd_data[ENTRY_W-6 -: 5];
        out_data_nxt.out_minute = rd_data[ENTRY_W-11 -: 6];
        out_data_nxt.out_tag    = tag_out_fmt(rd_data[TAG_BITS-1:0]);
        out_data_nxt.last       = idx_is_tail;
        if (idx_is_tail) begin
          state_nxt = ST_IDLE;
        end else begin
          rd_addr = idx_inc;
          idx_nxt = idx_inc;
        end
      end
    endcase

    out_data_nxt.entry_count = count_out_fmt(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    new_r      <= new_nxt;
    out_data_r <= out_data_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ hdl/sil_checker.sv @@
// ----------------------------------------------------------------------------
// sil_checker
// port-level assertions for the sorted insertion list
// ----------------------------------------------------------------------------
`include "sorted_insertion_list_assert.svh"

module sil_checker
  import sil_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input in_beat_t  in_data,
  input logic      out_valid,
  input out_beat_t out_data
);

  logic clear_take;
  logic listed_more;
  logic not_listed;

  assign clear_take  = start && !busy && (in_data.cmd == CMD_CLEAR);
  assign listed_more = out_valid && (out_data.status == STAT_LISTED) && !out_data.last;
  assign not_listed  = out_valid && (out_data.status != STAT_LISTED);

  `SIL_ASSERT_NOW(a_unlisted_zero, clk, rst_n, not_listed, (out_data.out_day == 5'd0) && (out_data.out_hour == 5'd0) && (out_data.out_minute == 6'd0) && (out_data.out_tag == 16'd0), "fields set on a non-listed result")
  `SIL_ASSERT_NOW(a_single_last, clk, rst_n, not_listed, out_data.last, "single result without last")
  `SIL_ASSERT_NEXT(a_clear_result, clk, rst_n, clear_take, out_valid && (out_data.status == STAT_EMPTY) && (out_data.entry_count == 6'd0), "clear result wrong")
  `SIL_ASSERT_NEXT(a_list_stream, clk, rst_n, listed_more, out_valid && (out_data.status == STAT_LISTED), "list stream broken")
  `SIL_ASSERT_NEXT(a_list_busy, clk, rst_n, listed_more, busy || out_data.last, "list ended early")

endmodule

bind sorted_insertion_list sil_checker u_sil_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_data  (out_data)
);

@@ test/sil_response_checker.sv @@
// ----------------------------------------------------------------------------
// sil_response_checker
// watches the command and result channels of the sorted insertion list,
// keeps its own sorted copy of the held entries, works out the result beats
// each accepted command owes and compares them field by field in order
// ----------------------------------------------------------------------------
module sil_response_checker
  import sil_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      busy,
  input  in_beat_t  in_data,
  input  logic      out_valid,
  input  out_beat_t out_data,
  output int        fail_count,
  output int        pending
);

  localparam int MIN_PER_HOUR = 60;

  logic [4:0]          held_day [CAPACITY];
  logic [10:0]         held_mod [CAPACITY];
  logic [TAG_BITS-1:0] held_tag [CAPACITY];
  int                  held_n;
  out_beat_t           owed_beats [$];

  initial begin
    fail_count = 0;
    pending    = 0;
    held_n     = 0;
  end

  function automatic void match_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", field, want, got);
      fail_count++;
    end
  endfunction

  task automatic apply_command(in_beat_t b);
    out_beat_t r;
    int        pos;
    int        mod;
    r      = '0;
    r.last = 1'b1;
    case (b.cmd)
      CMD_INSERT: begin
        if (b.entry_day == 7'd0 || b.entry_day > DAY_MAX || b.entry_hour > HOUR_MAX ||
            b.entry_minute > MINUTE_MAX) begin
          r.status = STAT_BAD_FMT;
        end else if (held_n >= CAPACITY) begin
          r.status = STAT_FULL;
        end else begin
          mod = int'(b.entry_hour) * MIN_PER_HOUR + int'(b.entry_minute);
          pos = 0;
          // equal keys stay behind the ones already held
          while (pos < held_n && !(held_day[pos] > b.entry_day ||
                 (held_day[pos] == b.entry_day && int'(held_mod[pos]) > mod))) begin
            pos++;
          end
          for (int i = held_n; i > pos; i--) begin
            held_day[i] = held_day[i-1];
            held_mod[i] = held_mod[i-1];
            held_tag[i] = held_tag[i-1];
          end
          held_day[pos] = b.entry_day[4:0];
          held_mod[pos] = 11'(mod);
          held_tag[pos] = TAG_BITS'(b.entry_tag);
          held_n++;
          r.status = STAT_INSERTED;
        end
        r.entry_count = 6'(held_n);
        owed_beats.push_back(r);
      end
      CMD_LIST: begin
        if (held_n == 0) begin
          r.status = STAT_EMPTY;
          owed_beats.push_back(r);
        end else begin
          for (int i = 0; i < held_n; i++) begin
            r.status      = STAT_LISTED;
            r.out_day     = held_day[i];
            r.out_hour    = 5'(int'(held_mod[i]) / MIN_PER_HOUR);
            r.out_minute  = 6'(int'(held_mod[i]) % MIN_PER_HOUR);
            r.out_tag     = 16'(held_tag[i]);
            r.last        = (i == held_n - 1);
            r.entry_count = 6'(held_n);
            owed_beats.push_back(r);
          end
        end
      end
      CMD_CLEAR: begin
        held_n   = 0;
        r.status = STAT_EMPTY;
        owed_beats.push_back(r);
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      held_n = 0;
      owed_beats.delete();
    end else begin
      if (out_valid) begin
        if (owed_beats.size() == 0) begin
          $error("result beat with none expected: status %0d", out_data.status);
          fail_count++;
        end else begin
          out_beat_t want;
          want = owed_beats.pop_front();
          match_field("status", want.status, out_data.status);
          match_field("out_day", want.out_day, out_data.out_day);
          match_field("out_hour", want.out_hour, out_data.out_hour);
          match_field("out_minute", want.out_minute, out_data.out_minute);
          match_field("out_tag", want.out_tag, out_data.out_tag);
          match_field("last", want.last, out_data.last);
          match_field("entry_count", want.entry_count, out_data.entry_count);
        end
      end
      if (start && !busy) apply_command(in_data);
    end
    pending = owed_beats.size();
  end

endmodule

@@ test/sorted_insertion_list_test.sv @@
// ----------------------------------------------------------------------------
// sorted_insertion_list_test
// drives insert, list and clear commands into the sorted insertion list:
// a directed pass over field limits, rejects and equal keys, then random
// traffic that fills, lists and clears the list under varying sender gaps;
// the response checker predicts and compares every result beat
// ----------------------------------------------------------------------------
module sorted_insertion_list_test;
  import sil_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 40;
  localparam int PHASE_ITEMS  = 150;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_beat_t  in_data;
  logic      out_valid;
  out_beat_t out_data;
  int        fail_count;
  int        pending;
  logic      took;

  sorted_insertion_list uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  sil_response_checker checker_i (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .fail_count(fail_count),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) took <= rst_n && start && !busy;

  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic in_beat_t cmd_beat(logic [1:0] cmd, int day, int hour, int minute,
                                        int tag);
    in_beat_t b;
    b.cmd          = cmd;
    b.entry_day    = 7'(day);
    b.entry_hour   = 5'(hour);
    b.entry_minute = 6'(minute);
    b.entry_tag    = 16'(tag);
    return b;
  endfunction

  function automatic in_beat_t random_beat();
    int pick;
    pick = $urandom_range(999);
    if (pick < 15)
      return cmd_beat(CMD_CLEAR, $urandom, $urandom, $urandom, $urandom);
    if (pick < 100)
      return cmd_beat(CMD_LIST, $urandom, $urandom, $urandom, $urandom);
    if (pick < 120)
      return cmd_beat(CMD_UNUSED, $urandom, $urandom, $urandom, $urandom);
    // whole field ranges, mostly bad format
    if (pick < 220)
      return cmd_beat(CMD_INSERT, $urandom, $urandom, $urandom, $urandom);
    // narrow key pool for many equal keys
    if (pick < 550)
      return cmd_beat(CMD_INSERT, $urandom_range(2, 1), $urandom_range(1), $urandom_range(1),
                      $urandom);
    return cmd_beat(CMD_INSERT, $urandom_range(31, 1), $urandom_range(23), $urandom_range(59),
                    $urandom);
  endfunction

  task automatic send_beat(in_beat_t b);
    in_data <= b;
    start   <= 1'b1;
    do @(negedge clk); while (!took);
  endtask

  task automatic hold_off(int pct);
    while ($urandom_range(99) < pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (pending != 0 || busy) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  initial begin
    int       idle_pct [3];
    int       sent;
    in_beat_t b;
    idle_pct = '{6, 76, 0};
    rst_n   = 1'b0;
    start   = 1'b0;
    in_data = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty list, rejects at every field limit
    send_beat(cmd_beat(CMD_LIST, 0, 0, 0, 0));
    send_beat(cmd_beat(CMD_CLEAR, 0, 0, 0, 0));
    send_beat(cmd_beat(CMD_INSERT, 0, 0, 0, 16'h1234));
    send_beat(cmd_beat(CMD_INSERT, 32, 0, 0, 0));
    send_beat(cmd_beat(CMD_INSERT, 127, 31, 63, 16'hffff));
    send_beat(cmd_beat(CMD_INSERT, 5, 24, 0, 0));
    send_beat(cmd_beat(CMD_INSERT, 5, 0, 60, 0));
    // extremes, equal keys keep arrival order
    send_beat(cmd_beat(CMD_INSERT, 31, 23, 59, 16'hffff));
    send_beat(cmd_beat(CMD_INSERT, 1, 0, 0, 16'h0000));
    send_beat(cmd_beat(CMD_INSERT, 15, 12, 30, 16'h1111));
    send_beat(cmd_beat(CMD_INSERT, 15, 12, 30, 16'h2222));
    send_beat(cmd_beat(CMD_INSERT, 15, 12, 29, 16'h3333));
    send_beat(cmd_beat(CMD_INSERT, 15, 12, 31, 16'h4444));
    send_beat(cmd_beat(CMD_INSERT, 1, 0, 0, 16'h5555));
    send_beat(cmd_beat(CMD_UNUSED, 99, 17, 42, 16'hbeef));
    send_beat(cmd_beat(CMD_LIST, 0, 0, 0, 0));
    send_beat(cmd_beat(CMD_CLEAR, 0, 0, 0, 0));
    send_beat(cmd_beat(CMD_LIST, 0, 0, 0, 0));
    send_beat(cmd_beat(CMD_INSERT, 31, 23, 59, 16'h8001));
    send_beat(cmd_beat(CMD_LIST, 0, 0, 0, 0));

    for (int phase = 0; phase < 3; phase++) begin
      wait_drained();
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        b = random_beat();
        send_beat(b);
        if (b.cmd != CMD_UNUSED) sent++;
        hold_off(idle_pct[phase]);
      end
    end

    wait_drained();
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
